// ===== rtl/core/hdlf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hdlf_pkg;

  localparam int BYTES_PER_LINE_DEF = 16;
  localparam int OFFSET_W           = 32;
  localparam int OFFSET_DIGITS      = 8;

  localparam logic [6:0] CH_COLON   = 7'h3a;
  localparam logic [6:0] CH_SPACE   = 7'h20;
  localparam logic [6:0] CH_NEWLINE = 7'h0a;
  localparam logic [6:0] CH_DOT     = 7'h2e;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFFSET,
    ST_COLON,
    ST_SEP,
    ST_HI,
    ST_LO,
    ST_PAIR,
    ST_PAD,
    ST_GAP,
    ST_TEXT,
    ST_NL
  } state_t;

  typedef enum logic [2:0] {
    SEL_OFFSET,
    SEL_COLON,
    SEL_SPACE,
    SEL_HEX_HI,
    SEL_HEX_LO,
    SEL_TEXT,
    SEL_NEWLINE
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    char_sel_t sel;
    logic      last;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      cnt_used;
    logic      commit;
  } cmd_t;

  typedef struct packed {
    logic can_emit;
    logic pos_zero;
    logic pos_odd;
    logic close;
    logic has_pad;
    logic digit_last;
    logic pad_last;
    logic text_last;
  } sts_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (7'h30 + {3'b000, nib}) : (7'h57 + {3'b000, nib});
  endfunction

  function automatic logic [6:0] text_char(input logic [7:0] b);
    return (b >= PRINT_LO && b <= PRINT_HI) ? b[6:0] : CH_DOT;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hdlf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hdlf_dp #(
  parameter int BYTES_PER_LINE = hdlf_pkg::BYTES_PER_LINE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_final_byte,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [6:0]         out_char_code,
  output logic               out_last_in_run,
  input  hdlf_pkg::cmd_t     cmd,
  output hdlf_pkg::sts_t     sts
);

  localparam int HexArea = BYTES_PER_LINE * 2 + BYTES_PER_LINE / 2;
  localparam int IdxW    = $clog2(BYTES_PER_LINE);
  localparam int PosW    = $clog2(BYTES_PER_LINE + 1);
  localparam int CntW    = $clog2(HexArea + 1);

  logic [7:0]                   line_r [BYTES_PER_LINE];
  logic [7:0]                   byte_r;
  logic                         fin_r;
  logic [PosW-1:0]              pos_r;
  logic [hdlf_pkg::OFFSET_W-1:0] offset_r;
  logic [CntW-1:0]              cnt_r;
  logic                         out_valid_r;
  logic [6:0]                   char_r;
  logic                         last_r;

  logic [PosW-1:0]              npos;
  logic [CntW-1:0]              used;
  logic                         close;
  logic [hdlf_pkg::OFFSET_W-1:0] off_sh;
  logic [6:0]                   char_nxt;

  assign npos   = pos_r + PosW'(1);
  assign used   = CntW'({npos, 1'b0}) + CntW'(npos >> 1);
  assign close  = (npos == PosW'(BYTES_PER_LINE)) || fin_r;
  assign off_sh = offset_r >> {~cnt_r[2:0], 2'b00};

  always_comb begin
    sts.can_emit   = !out_valid_r || !out_stall;
    sts.pos_zero   = (pos_r == '0);
    sts.pos_odd    = pos_r[0];
    sts.close      = close;
    sts.has_pad    = (used < CntW'(HexArea));
    sts.digit_last = (cnt_r == CntW'(hdlf_pkg::OFFSET_DIGITS - 1));
    sts.pad_last   = (cnt_r == CntW'(HexArea - 1));
    sts.text_last  = (cnt_r == CntW'(pos_r));
  end

  always_comb begin
    unique case (cmd.sel)
      hdlf_pkg::SEL_OFFSET:  char_nxt = hdlf_pkg::hex_char(off_sh[3:0]);
      hdlf_pkg::SEL_COLON:   char_nxt = hdlf_pkg::CH_COLON;
      hdlf_pkg::SEL_SPACE:   char_nxt = hdlf_pkg::CH_SPACE;
      hdlf_pkg::SEL_HEX_HI:  char_nxt = hdlf_pkg::hex_char(byte_r[7:4]);
      hdlf_pkg::SEL_HEX_LO:  char_nxt = hdlf_pkg::hex_char(byte_r[3:0]);
      hdlf_pkg::SEL_TEXT:    char_nxt = hdlf_pkg::text_char(line_r[cnt_r[IdxW-1:0]]);
      hdlf_pkg::SEL_NEWLINE: char_nxt = hdlf_pkg::CH_NEWLINE;
      default:               char_nxt = hdlf_pkg::CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      line_r[pos_r[IdxW-1:0]] <= in_data_byte;
      byte_r                  <= in_data_byte;
      fin_r                   <= in_final_byte;
    end
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_used) begin
      cnt_r <= used;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CntW'(1);
    end
    if (cmd.emit) begin
      char_r <= char_nxt;
      last_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        pos_r <= close ? '0 : npos;
        if (close) begin
          offset_r <= fin_r ? '0 : offset_r + hdlf_pkg::OFFSET_W'(BYTES_PER_LINE);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_code   = char_r;
  assign out_last_in_run = last_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < PosW'(BYTES_PER_LINE))
    else $error("line position out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(char_r) && $stable(last_r)))
    else $error("stalled word changed");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("word loaded over a stalled word");

endmodule

`default_nettype wire

// ===== rtl/core/hdlf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hdlf_ctrl (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  hdlf_pkg::sts_t sts,
  output hdlf_pkg::cmd_t cmd
);

  hdlf_pkg::state_t state_r;
  hdlf_pkg::state_t state_nxt;
  hdlf_pkg::state_t after_hex;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hdlf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    after_hex = sts.close ? (sts.has_pad ? hdlf_pkg::ST_PAD : hdlf_pkg::ST_GAP)
                          : hdlf_pkg::ST_IDLE;
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.emit     = 1'b0;
    cmd.sel      = hdlf_pkg::SEL_SPACE;
    cmd.last     = 1'b0;
    cmd.cnt_clr  = 1'b0;
    cmd.cnt_inc  = 1'b0;
    cmd.cnt_used = 1'b0;
    cmd.commit   = 1'b0;
    in_stall     = (state_r != hdlf_pkg::ST_IDLE);
    unique case (state_r)
      hdlf_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = sts.pos_zero ? hdlf_pkg::ST_OFFSET : hdlf_pkg::ST_HI;
        end
      end
      hdlf_pkg::ST_OFFSET: begin
        cmd.sel = hdlf_pkg::SEL_OFFSET;
        if (sts.can_emit) begin
          cmd.emit    = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (sts.digit_last) begin
            state_nxt = hdlf_pkg::ST_COLON;
          end
        end
      end
      hdlf_pkg::ST_COLON: begin
        cmd.sel = hdlf_pkg::SEL_COLON;
        if (sts.can_emit) begin
          cmd.emit  = 1'b1;
          state_nxt = hdlf_pkg::ST_SEP;
        end
      end
      hdlf_pkg::ST_SEP: begin
        cmd.sel = hdlf_pkg::SEL_SPACE;
        if (sts.can_emit) begin
          cmd.emit  = 1'b1;
          state_nxt = hdlf_pkg::ST_HI;
        end
      end
      hdlf_pkg::ST_HI: begin
        cmd.sel = hdlf_pkg::SEL_HEX_HI;
        if (sts.can_emit) begin
          cmd.emit  = 1'b1;
          state_nxt = hdlf_pkg::ST_LO;
        end
      end
      hdlf_pkg::ST_LO: begin
        cmd.sel  = hdlf_pkg::SEL_HEX_LO;
        cmd.last = !sts.pos_odd && !sts.close;
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          if (sts.pos_odd) begin
            state_nxt = hdlf_pkg::ST_PAIR;
          end else begin
            state_nxt    = after_hex;
            cmd.commit   = !sts.close;
            cmd.cnt_used = sts.close;
          end
        end
      end
      hdlf_pkg::ST_PAIR: begin
        cmd.sel  = hdlf_pkg::SEL_SPACE;
        cmd.last = !sts.close;
        if (sts.can_emit) begin
          cmd.emit     = 1'b1;
          state_nxt    = after_hex;
          cmd.commit   = !sts.close;
          cmd.cnt_used = sts.close;
        end
      end
      hdlf_pkg::ST_PAD: begin
        cmd.sel = hdlf_pkg::SEL_SPACE;
        if (sts.can_emit) begin
          cmd.emit    = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (sts.pad_last) begin
            state_nxt = hdlf_pkg::ST_GAP;
          end
        end
      end
      hdlf_pkg::ST_GAP: begin
        cmd.sel = hdlf_pkg::SEL_SPACE;
        if (sts.can_emit) begin
          cmd.emit    = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = hdlf_pkg::ST_TEXT;
        end
      end
      hdlf_pkg::ST_TEXT: begin
        cmd.sel = hdlf_pkg::SEL_TEXT;
        if (sts.can_emit) begin
          cmd.emit    = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (sts.text_last) begin
            state_nxt = hdlf_pkg::ST_NL;
          end
        end
      end
      hdlf_pkg::ST_NL: begin
        cmd.sel  = hdlf_pkg::SEL_NEWLINE;
        cmd.last = 1'b1;
        if (sts.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.commit = 1'b1;
          state_nxt  = hdlf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hdlf_pkg::ST_IDLE;
      end
    endcase
  end

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hdlf_pkg::ST_IDLE) |-> !cmd.emit)
    else $error("word emitted while idle");

  a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (cmd.emit && cmd.last))
    else $error("line state updated without final word");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r != hdlf_pkg::ST_IDLE))
    else $error("accepted byte produced no output");

endmodule

`default_nettype wire

// ===== rtl/core/hex_dump_line_formatter.sv =====
// each accepted byte is registered, then its first character enters char_r
// throughput: one character per cycle from a single output register while out_stall
//   is low; a new byte is taken only after every character of the last one is
//   emitted (offset, hex digits, padding, text and newline all serial)
// reset: synchronous active-low rst_n clears line position, offset and output valid
`timescale 1ns / 1ps
`default_nettype none

module hex_dump_line_formatter #(
  parameter int BYTES_PER_LINE = hdlf_pkg::BYTES_PER_LINE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_final_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      out_char_code,
  output logic            out_last_in_run
);

  hdlf_pkg::cmd_t cmd;
  hdlf_pkg::sts_t sts;

  hdlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hdlf_dp #(
    .BYTES_PER_LINE (BYTES_PER_LINE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_char_code   (out_char_code),
    .out_last_in_run (out_last_in_run),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire

// ===== tb/sv/hex_dump_line_formatter_test.sv =====
`timescale 1ns / 1ps

module hex_dump_line_formatter_test;

  localparam int LINE_BYTES = hdlf_pkg::BYTES_PER_LINE_DEF;
  localparam int HEX_COLS = LINE_BYTES * 2 + LINE_BYTES / 2;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } dump_char_t;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    string      lit;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_final_byte;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] out_char_code;
  logic       out_last_in_run;

  dump_char_t pending_chars[$];
  dump_char_t byte_chars[$];
  dump_char_t want;
  int         n_errors = 0;
  int         n_checked = 0;
  int         n_taken = 0;

  logic [7:0]  line_buf [LINE_BYTES];
  int unsigned line_fill = 0;
  logic [31:0] line_addr = 32'd0;

  // first line: typed text where it reads off at a glance, then odd/even/single-word closes
  plan_row_t plan [23] = '{
    '{8'h00, 1'b0, "00000000: 00"},
    '{8'hff, 1'b0, "ff "},
    '{8'h41, 1'b0, "41"},
    '{8'h7e, 1'b0, "7e "},
    '{8'h7f, 1'b0, "7f"},
    '{8'h20, 1'b0, "20 "},
    '{8'h1f, 1'b0, ""},
    '{8'h80, 1'b0, ""},
    '{8'h7a, 1'b0, ""},
    '{8'h30, 1'b0, ""},
    '{8'h39, 1'b0, ""},
    '{8'h61, 1'b0, ""},
    '{8'h66, 1'b0, ""},
    '{8'h0a, 1'b0, ""},
    '{8'h2e, 1'b0, ""},
    '{8'h5c, 1'b0, ""},
    '{8'h55, 1'b1, ""},
    '{8'h00, 1'b1, ""},
    '{8'hff, 1'b0, ""},
    '{8'h21, 1'b0, ""},
    '{8'h7f, 1'b1, ""},
    '{8'h80, 1'b0, ""},
    '{8'h7e, 1'b1, ""}
  };

  hex_dump_line_formatter #(
    .BYTES_PER_LINE(LINE_BYTES)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_final_byte  (in_final_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_code  (out_char_code),
    .out_last_in_run(out_last_in_run)
  );

  always #5 clk = ~clk;

  function automatic logic [6:0] nib_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 7'h30 + 7'(nib);
    end
    return 7'h61 + 7'(nib) - 7'd10;
  endfunction

  function automatic void put_char(input logic [6:0] c);
    byte_chars.push_back('{code: c, last: 1'b0});
  endfunction

  // characters made ready by one word, line state advanced
  function automatic void format_byte(input logic [7:0] b, input logic fin);
    int unsigned pos;
    int unsigned used;
    byte_chars.delete();
    pos = line_fill;
    if (pos == 0) begin
      for (int s = 7; s >= 0; s--) put_char(nib_char(line_addr[s * 4 +: 4]));
      put_char(hdlf_pkg::CH_COLON);
      put_char(hdlf_pkg::CH_SPACE);
    end
    line_buf[pos] = b;
    put_char(nib_char(b[7:4]));
    put_char(nib_char(b[3:0]));
    if (pos % 2 == 1) begin
      put_char(hdlf_pkg::CH_SPACE);
    end
    pos++;
    if (pos == LINE_BYTES || fin) begin
      used = pos * 2 + pos / 2;
      for (int unsigned i = used; i < HEX_COLS; i++) put_char(hdlf_pkg::CH_SPACE);
      put_char(hdlf_pkg::CH_SPACE);
      for (int unsigned i = 0; i < pos; i++) begin
        if (line_buf[i] >= hdlf_pkg::PRINT_LO && line_buf[i] <= hdlf_pkg::PRINT_HI) begin
          put_char(line_buf[i][6:0]);
        end else begin
          put_char(hdlf_pkg::CH_DOT);
        end
      end
      put_char(hdlf_pkg::CH_NEWLINE);
      line_addr = fin ? 32'd0 : line_addr + LINE_BYTES;
      pos = 0;
    end
    line_fill = pos;
    byte_chars[byte_chars.size() - 1].last = 1'b1;
  endfunction

  function automatic void note_error(input string msg);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%s", msg);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, input string lit,
                           input bit rush);
    int  gap;
    byte ch;
    gap = rush ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    format_byte(b, fin);
    if (lit.len() == 0) begin
      foreach (byte_chars[i]) pending_chars.push_back(byte_chars[i]);
    end else begin
      for (int i = 0; i < lit.len(); i++) begin
        ch = lit[i];
        pending_chars.push_back('{code: ch[6:0], last: (i == lit.len() - 1)});
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  initial begin
    int rand_items;
    int len;
    int pick;
    bit closes;
    bit rush;
    bit first;
    bit paused;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_final_byte = 1'b0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) send_byte(plan[i].data, plan[i].fin, plan[i].lit, 1'b0);
    wait_drained();

    rand_items = 0;
    first = 1'b1;
    paused = 1'b0;
    while (rand_items < 96) begin
      pick = $urandom_range(0, 9);
      if (first || pick == 0) begin
        len = LINE_BYTES;
      end else if (pick == 1) begin
        len = 2 * LINE_BYTES;
      end else if (pick == 2) begin
        len = LINE_BYTES + 1;
      end else begin
        len = $urandom_range(1, 12);
      end
      closes = first || ($urandom_range(0, 4) != 0);
      rush = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(0, 255)), closes && (i == len - 1), "", rush);
      end
      rand_items += len;
      first = 1'b0;
      if (!paused && rand_items >= 48) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    wait_drained();
    repeat (60) @(posedge clk);
    if (n_errors == 0 && pending_chars.size() == 0) begin
      $display("hex_dump_line_formatter_test: clean");
    end else begin
      $display("hex_dump_line_formatter_test: errors");
    end
    $finish;
  end

  // output side stall, one long hold-off early in the random stream so the input backs up
  initial begin
    int hold;
    bit quiet;
    out_stall = 1'b0;
    quiet = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        n_taken++;
        if (n_taken % 40 == 0) begin
          quiet = ($urandom_range(0, 2) == 0);
        end
        if (n_taken == 300) begin
          hold = 600;
        end else if (quiet) begin
          hold = 0;
        end else begin
          hold = $urandom_range(0, 16);
        end
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        note_error($sformatf("char %0d: none expected, got code %02h last %0b",
                             n_checked, out_char_code, out_last_in_run));
      end else begin
        want = pending_chars.pop_front();
        if (want.code !== out_char_code || want.last !== out_last_in_run) begin
          note_error($sformatf("char %0d: expected code %02h last %0b, got code %02h last %0b",
                               n_checked, want.code, want.last, out_char_code,
                               out_last_in_run));
        end
      end
      n_checked++;
    end
  end

  initial begin
    #10_000_000;
    $display("hex_dump_line_formatter_test: errors");
    $finish;
  end

endmodule
